// ===== src/srrd_pkg.sv =====
// shared types and constants of the row run star detector
`timescale 1ns / 1ps
package srrd_pkg;

  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  // widest column index over the whole MAX_WIDTH range
  localparam int COL_MAX_BITS    = 14;

  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_BLACK_LEVEL   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD     = 2'd2;
  localparam logic [1:0] REG_MIN_RUN_WIDTH = 2'd3;

  localparam logic [39:0] WSUM_MAX = {40{1'b1}};
  localparam logic [27:0] FLUX_MAX = {28{1'b1}};
  localparam logic [12:0] WCNT_MAX = {13{1'b1}};

  typedef struct packed {
    logic [15:0] sample;
    logic        frame_start;
  } in_t;

  typedef struct packed {
    logic [11:0] center_col;
    logic [11:0] row_index;
    logic [12:0] run_width;
    logic [27:0] run_flux;
    logic [15:0] center_value;
  } out_t;

  // closed run handed from front to back
  typedef struct packed {
    logic [39:0]             wsum;
    logic [27:0]             flux;
    logic [12:0]             width;
    logic [11:0]             row;
    logic [COL_MAX_BITS-1:0] last_col;
  } job_t;

endpackage

// ===== src/srrd_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module srrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/srrd_fifo.sv =====
// two entry queue of closed runs
`timescale 1ns / 1ps
module srrd_fifo
  import srrd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic empty,
  output logic full
);
  job_t       mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !full) begin
      wptr_nxt = ~wptr_r;
      cnt_nxt  = cnt_nxt + 2'd1;
    end
    if (pop && !empty) begin
      rptr_nxt = ~rptr_r;
      cnt_nxt  = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wptr_r] <= push_data;
    end
  end
endmodule

// ===== src/srrd_front.sv =====
// pixel front end: black correction, row store write, run accumulation
`timescale 1ns / 1ps
module srrd_front
  import srrd_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [16:0]                  cfg_wdata,
  input  logic                         accept,
  input  in_t                          pix,
  output logic                         ram_we,
  output logic [$clog2(MAX_WIDTH)-1:0] ram_waddr,
  output logic [SAMPLE_BITS-1:0]       ram_wdata,
  output logic                         job_push,
  output job_t                         job
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = 21;

  logic [12:0] image_width_r, min_run_width_r;
  logic [15:0] black_level_r;
  logic [16:0] threshold_r;

  logic [AW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;
  logic [39:0]   ws_r, ws_nxt;
  logic [27:0]   fl_r, fl_nxt;
  logic [12:0]   wc_r, wc_nxt;
  logic [1:0]    dc_r, dc_nxt;

  logic [AW-1:0]          col;
  logic [11:0]            row;
  logic [39:0]            ws_b;
  logic [27:0]            fl_b;
  logic [12:0]            wc_b;
  logic [1:0]             dc_b;
  logic [EW-1:0]          raw, blk;
  logic [SAMPLE_BITS-1:0] v;
  logic [AW+SAMPLE_BITS-1:0] prod;
  logic [40:0]            ws_add;
  logic [28:0]            fl_add;
  logic [39:0]            ws_sat;
  logic [27:0]            fl_sat;
  logic [12:0]            wc_inc;
  logic [14:0]            eff_width;
  logic                   close_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= 13'd640;
      black_level_r   <= 16'd0;
      threshold_r     <= 17'd64;
      min_run_width_r <= 13'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width_r   <= cfg_wdata[12:0];
        REG_BLACK_LEVEL:   black_level_r   <= cfg_wdata[15:0];
        REG_THRESHOLD:     threshold_r     <= cfg_wdata;
        REG_MIN_RUN_WIDTH: min_run_width_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col  = pix.frame_start ? '0 : col_r;
    row  = pix.frame_start ? 12'd0 : row_r;
    ws_b = (col == '0) ? 40'd0 : ws_r;
    fl_b = (col == '0) ? 28'd0 : fl_r;
    wc_b = (col == '0) ? 13'd0 : wc_r;
    dc_b = (col == '0) ? 2'd0 : dc_r;

    raw = EW'(SAMPLE_BITS'(pix.sample));
    blk = EW'(black_level_r);
    v   = (raw > blk) ? SAMPLE_BITS'(raw - blk) : '0;

    prod   = AW'(col) * v;
    ws_add = 41'(ws_b) + 41'(prod);
    fl_add = 29'(fl_b) + 29'(v);
    ws_sat = ws_add[40] ? WSUM_MAX : ws_add[39:0];
    fl_sat = fl_add[28] ? FLUX_MAX : fl_add[27:0];
    wc_inc = (wc_b == WCNT_MAX) ? wc_b : wc_b + 13'd1;

    ws_nxt    = ws_b;
    fl_nxt    = fl_b;
    wc_nxt    = wc_b;
    dc_nxt    = dc_b;
    close_run = 1'b0;
    if (EW'(v) >= EW'(threshold_r)) begin
      dc_nxt = 2'd0;
      ws_nxt = ws_sat;
      fl_nxt = fl_sat;
      wc_nxt = wc_inc;
    end else if (wc_b != 13'd0 && dc_b <= 2'd2) begin
      dc_nxt = dc_b + 2'd1;
      ws_nxt = ws_sat;
      fl_nxt = fl_sat;
      wc_nxt = wc_inc;
    end else if (wc_b != 13'd0) begin
      close_run = 1'b1;
      ws_nxt    = 40'd0;
      fl_nxt    = 28'd0;
      wc_nxt    = 13'd0;
      dc_nxt    = 2'd0;
    end

    // out of range widths fold to 1 or MAX_WIDTH
    if (image_width_r == 13'd0) begin
      eff_width = 15'd1;
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      eff_width = 15'(MAX_WIDTH);
    end else begin
      eff_width = 15'(image_width_r);
    end
    if (16'(col) + 16'd1 >= 16'(eff_width)) begin
      col_nxt = '0;
      row_nxt = row + 12'd1;
    end else begin
      col_nxt = col + AW'(1);
      row_nxt = row;
    end
  end

  assign ram_we    = accept;
  assign ram_waddr = col;
  assign ram_wdata = v;
  assign job_push  = accept && close_run && (wc_b >= min_run_width_r);

  always_comb begin
    job.wsum     = ws_b;
    job.flux     = fl_b;
    job.width    = wc_b;
    job.row      = row;
    job.last_col = COL_MAX_BITS'((col == '0) ? col : col - AW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 12'd0;
      ws_r  <= 40'd0;
      fl_r  <= 28'd0;
      wc_r  <= 13'd0;
      dc_r  <= 2'd0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ws_r  <= ws_nxt;
      fl_r  <= fl_nxt;
      wc_r  <= wc_nxt;
      dc_r  <= dc_nxt;
    end
  end
endmodule

// ===== src/srrd_back.sv =====
// run back end: center division, center pixel lookup, output register
`timescale 1ns / 1ps
module srrd_back
  import srrd_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_empty,
  input  job_t                         job,
  output logic                         job_pop,
  output logic                         busy,
  output logic [$clog2(MAX_WIDTH)-1:0] ram_raddr,
  input  logic [SAMPLE_BITS-1:0]       ram_rdata,
  output logic                         out_valid,
  output out_t                         out_data,
  input  logic                         out_stall
);
  localparam int AW = $clog2(MAX_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [41:0]   num_r, num_nxt;
  logic [28:0]   den_r, den_nxt;
  logic [28:0]   rem_r, rem_nxt;
  logic [COL_MAX_BITS:0] q_r, q_nxt;
  logic          ovf_r, ovf_nxt;
  logic          zero_r, zero_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [AW-1:0] ctr_r, ctr_nxt;
  logic [11:0]   row_r, row_nxt;
  logic [12:0]   wid_r, wid_nxt;
  logic [27:0]   flux_r, flux_nxt;
  logic          ov_r, ov_nxt;
  out_t          od_r, od_nxt;

  logic [29:0] rem_sh;
  logic        ge;
  logic        out_free;

  assign out_free  = !ov_r || !out_stall;
  assign busy      = (state_r != ST_IDLE);
  assign job_pop   = (state_r == ST_IDLE) && !job_empty;
  assign ram_raddr = ctr_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    ovf_nxt   = ovf_r;
    zero_nxt  = zero_r;
    last_nxt  = last_r;
    ctr_nxt   = ctr_r;
    row_nxt   = row_r;
    wid_nxt   = wid_r;
    flux_nxt  = flux_r;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;

    rem_sh = {rem_r, num_r[41]};
    ge     = rem_sh >= {1'b0, den_r};

    case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          // center = (2*wsum + flux) / (2*flux)
          num_nxt   = {job.wsum, 1'b0} + 42'(job.flux);
          den_nxt   = {job.flux, 1'b0};
          rem_nxt   = 29'd0;
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          zero_nxt  = (job.flux == 28'd0);
          last_nxt  = AW'(job.last_col);
          row_nxt   = job.row;
          wid_nxt   = job.width;
          flux_nxt  = job.flux;
          cnt_nxt   = 6'd41;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? 29'(rem_sh - {1'b0, den_r}) : rem_sh[28:0];
        ovf_nxt = ovf_r | q_r[COL_MAX_BITS];
        q_nxt   = {q_r[COL_MAX_BITS-1:0], ge};
        num_nxt = {num_r[40:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // clamp to the last run pixel; zero flux takes it too
        if (zero_r || ovf_r || 16'(q_r) > 16'(last_r)) begin
          ctr_nxt = last_r;
        end else begin
          ctr_nxt = AW'(q_r);
        end
        state_nxt = ST_LOAD;
        cnt_nxt   = 6'd1;
      end
      ST_LOAD: begin
        // wait out the registered read, then wait for the output
        if (cnt_r != 6'd0) begin
          cnt_nxt = 6'd0;
        end else if (out_free) begin
          ov_nxt              = 1'b1;
          od_nxt.center_col   = 12'(ctr_r);
          od_nxt.row_index    = row_r;
          od_nxt.run_width    = wid_r;
          od_nxt.run_flux     = flux_r;
          od_nxt.center_value = 16'(ram_rdata);
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    ovf_r  <= ovf_nxt;
    zero_r <= zero_nxt;
    last_r <= last_nxt;
    ctr_r  <= ctr_nxt;
    row_r  <= row_nxt;
    wid_r  <= wid_nxt;
    flux_r <= flux_nxt;
    od_r   <= od_nxt;
  end
endmodule

// ===== src/star_row_run_detector.sv =====
// top level of the row run star detector
//
//  port group  direction  moves
//  in_*        input      one pixel request: sample, frame_start
//  out_*       output     one run record request
//  cfg_*       input      register write: index, data
//
//  pixels are taken back to back while no run waits in the queue or is in the
//  back end. a closed run holds the input off while the back end takes it
//  from the queue, runs the bit-serial center division, clamps the center
//  and reads the row store; a stalled earlier record adds its wait.
//  out_stall only holds the output register; pixels still flow behind it
//  until the next run closes.
//  reset is synchronous on rst_n; the row store is not cleared.
`timescale 1ns / 1ps
module star_row_run_detector
  import srrd_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  localparam int AW = $clog2(MAX_WIDTH);

  logic                   accept;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
  logic                   job_push, job_pop, job_empty, job_full, busy;
  job_t                   job_in, job_out;

  // the back end reads the row store, so the front waits until it is done
  assign in_stall = !job_empty || job_full || busy;
  assign accept   = in_valid && !in_stall;

  srrd_front #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pix       (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_push  (job_push),
    .job       (job_in)
  );

  srrd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srrd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty),
    .full      (job_full)
  );

  srrd_back #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .busy      (busy),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );
endmodule

// ===== src/srrd_checker.sv =====
// port level checks of the row run star detector and their bind
`timescale 1ns / 1ps
module srrd_checker
  import srrd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled record changed");

  a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.run_width != 13'd0)
    else $error("record with zero width");

  // a new record only comes out of a busy back end
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("record appeared while input was open");
endmodule

bind star_row_run_detector srrd_checker u_srrd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
